### rtl/stf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stf_pkg;

  localparam int unsigned DEF_MAG_WIDTH    = 32;
  localparam int unsigned DEF_MAX_LOG2_LEN = 12;
  localparam int unsigned MIN_LOG2_LEN     = 4;

  localparam int unsigned LOG2_LEN_W = 4;
  localparam int unsigned RATE_W     = 27;
  localparam int unsigned DC_W       = 28;
  localparam int unsigned FREQ_W     = 26;
  localparam int unsigned AMP_W      = 29;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [LOG2_LEN_W-1:0] LOG2_LEN_RST = LOG2_LEN_W'(10);
  localparam logic [RATE_W-1:0]     RATE_RST     = RATE_W'(1000000);

  typedef enum logic {
    REG_LOG2_LEN = 1'b0,
    REG_RATE     = 1'b1
  } reg_idx_e;

endpackage

`default_nettype wire

### rtl/stf_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

module stf_tracker
  import stf_pkg::*;
#(
  parameter int unsigned MAG_WIDTH    = DEF_MAG_WIDTH,
  parameter int unsigned MAX_LOG2_LEN = DEF_MAX_LOG2_LEN,
  parameter int unsigned LW           = $clog2(MAX_LOG2_LEN + 1),
  parameter int unsigned IW           = MAX_LOG2_LEN - 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [LW-1:0]        eff_l_i,
  input  wire logic                 bin_valid_i,
  input  wire logic [MAG_WIDTH-1:0] bin_magnitude_i,
  output logic                      bin_stall_o,
  output logic                      snap_valid_o,
  input  wire logic                 snap_ready_i,
  output logic [MAG_WIDTH-1:0]      snap_dc_o,
  output logic [MAG_WIDTH-1:0]      snap_p1v_o,
  output logic [MAG_WIDTH-1:0]      snap_p2v_o,
  output logic [IW-1:0]             snap_p1i_o,
  output logic [IW-1:0]             snap_p2i_o
);

  localparam int unsigned CW = MAX_LOG2_LEN;

  logic [CW-1:0]        count_q;
  logic [MAG_WIDTH-1:0] dc_q;
  logic [MAG_WIDTH-1:0] p1v_q;
  logic [MAG_WIDTH-1:0] p2v_q;
  logic [IW-1:0]        p1i_q;
  logic [IW-1:0]        p2i_q;

  logic                 snap_v_q;
  logic [MAG_WIDTH-1:0] snap_dc_q;
  logic [MAG_WIDTH-1:0] snap_p1v_q;
  logic [MAG_WIDTH-1:0] snap_p2v_q;
  logic [IW-1:0]        snap_p1i_q;
  logic [IW-1:0]        snap_p2i_q;

  logic [CW-1:0] last_pos;
  logic [CW-1:0] upper_mask;
  logic          accept;
  logic          last;
  logic          in_half;

  assign last_pos   = ~({CW{1'b1}} << eff_l_i);
  assign upper_mask = {CW{1'b1}} << (eff_l_i - LW'(1));
  assign last       = (count_q >= last_pos);
  assign in_half    = ((count_q & upper_mask) == '0);

  assign bin_stall_o = snap_v_q & ~snap_ready_i;
  assign accept      = bin_valid_i & ~bin_stall_o;

  // frame tracking: dc capture, top-two update with strict compare
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      dc_q    <= '0;
      p1v_q   <= '0;
      p2v_q   <= '0;
      p1i_q   <= '0;
      p2i_q   <= '0;
    end else if (accept) begin
      if (last) begin
        count_q <= '0;
        dc_q    <= '0;
        p1v_q   <= '0;
        p2v_q   <= '0;
        p1i_q   <= '0;
        p2i_q   <= '0;
      end else begin
        count_q <= count_q + CW'(1);
        if (count_q == '0) begin
          dc_q <= bin_magnitude_i;
        end else if (in_half) begin
          if (bin_magnitude_i > p1v_q) begin
            p2v_q <= p1v_q;
            p2i_q <= p1i_q;
            p1v_q <= bin_magnitude_i;
            p1i_q <= count_q[IW-1:0];
          end else if (bin_magnitude_i > p2v_q) begin
            p2v_q <= bin_magnitude_i;
            p2i_q <= count_q[IW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_v_q <= 1'b0;
    end else if (accept && last) begin
      snap_v_q <= 1'b1;
    end else if (snap_ready_i) begin
      snap_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last) begin
      snap_dc_q  <= dc_q;
      snap_p1v_q <= p1v_q;
      snap_p2v_q <= p2v_q;
      snap_p1i_q <= p1i_q;
      snap_p2i_q <= p2i_q;
    end
  end

  assign snap_valid_o = snap_v_q;
  assign snap_dc_o    = snap_dc_q;
  assign snap_p1v_o   = snap_p1v_q;
  assign snap_p2v_o   = snap_p2v_q;
  assign snap_p1i_o   = snap_p1i_q;
  assign snap_p2i_o   = snap_p2i_q;

  a_peak_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1v_q >= p2v_q)
    else $error("second peak exceeds first peak");

  a_peak_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p2v_q != '0) |-> (p1i_q != p2i_q))
    else $error("both peaks share one index");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last) |=> (snap_v_q && count_q == '0 && p1v_q == '0))
    else $error("frame end did not load snapshot and clear trackers");

  a_snap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (snap_v_q && !snap_ready_i) |=> (snap_v_q && $stable(snap_p1v_q)
                                     && $stable(snap_dc_q)))
    else $error("held snapshot changed");

endmodule

`default_nettype wire

### rtl/stf_scale.sv
`timescale 1ns / 1ps
`default_nettype none

module stf_scale
  import stf_pkg::*;
#(
  parameter int unsigned MAG_WIDTH    = DEF_MAG_WIDTH,
  parameter int unsigned MAX_LOG2_LEN = DEF_MAX_LOG2_LEN,
  parameter int unsigned LW           = $clog2(MAX_LOG2_LEN + 1),
  parameter int unsigned IW           = MAX_LOG2_LEN - 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [LW-1:0]        eff_l_i,
  input  wire logic [RATE_W-1:0]    rate_i,
  input  wire logic                 snap_valid_i,
  output logic                      snap_ready_o,
  input  wire logic [MAG_WIDTH-1:0] snap_dc_i,
  input  wire logic [MAG_WIDTH-1:0] snap_p1v_i,
  input  wire logic [MAG_WIDTH-1:0] snap_p2v_i,
  input  wire logic [IW-1:0]        snap_p1i_i,
  input  wire logic [IW-1:0]        snap_p2i_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [DC_W-1:0]           dc_level_o,
  output logic [FREQ_W-1:0]         peak1_freq_hz_o,
  output logic [FREQ_W-1:0]         peak2_freq_hz_o,
  output logic [AMP_W-1:0]          peak1_level_o,
  output logic [AMP_W-1:0]          peak2_level_o
);

  localparam int unsigned PW = IW + RATE_W;
  localparam int unsigned AW = MAG_WIDTH + 1;

  logic                 prod_v_q;
  logic [PW-1:0]        prod1_q;
  logic [PW-1:0]        prod2_q;
  logic [MAG_WIDTH-1:0] dc_q;
  logic [MAG_WIDTH-1:0] p1v_q;
  logic [MAG_WIDTH-1:0] p2v_q;

  logic              out_v_q;
  logic [DC_W-1:0]   dc_level_q;
  logic [FREQ_W-1:0] peak1_freq_q;
  logic [FREQ_W-1:0] peak2_freq_q;
  logic [AMP_W-1:0]  peak1_level_q;
  logic [AMP_W-1:0]  peak2_level_q;

  logic          out_ready;
  logic          prod_ready;
  logic [AW-1:0] amp1_sh;
  logic [AW-1:0] amp2_sh;

  assign out_ready    = ~out_v_q | ~out_stall_i;
  assign prod_ready   = ~prod_v_q | out_ready;
  assign snap_ready_o = prod_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else if (prod_ready) begin
      prod_v_q <= snap_valid_i;
    end
  end

  // multiply stage: index times rate
  always_ff @(posedge clk_i) begin
    if (prod_ready && snap_valid_i) begin
      prod1_q <= PW'(snap_p1i_i) * PW'(rate_i);
      prod2_q <= PW'(snap_p2i_i) * PW'(rate_i);
      dc_q    <= snap_dc_i;
      p1v_q   <= snap_p1v_i;
      p2v_q   <= snap_p2v_i;
    end
  end

  assign amp1_sh = {p1v_q, 1'b0} >> eff_l_i;
  assign amp2_sh = {p2v_q, 1'b0} >> eff_l_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ready) begin
      out_v_q <= prod_v_q;
    end
  end

  // shift stage: divide by the transform length, amplitudes doubled first
  always_ff @(posedge clk_i) begin
    if (out_ready && prod_v_q) begin
      dc_level_q    <= DC_W'(dc_q >> eff_l_i);
      peak1_freq_q  <= FREQ_W'(prod1_q >> eff_l_i);
      peak2_freq_q  <= FREQ_W'(prod2_q >> eff_l_i);
      peak1_level_q <= AMP_W'(amp1_sh);
      peak2_level_q <= AMP_W'(amp2_sh);
    end
  end

  assign out_valid_o     = out_v_q;
  assign dc_level_o      = dc_level_q;
  assign peak1_freq_hz_o = peak1_freq_q;
  assign peak2_freq_hz_o = peak2_freq_q;
  assign peak1_level_o   = peak1_level_q;
  assign peak2_level_o   = peak2_level_q;

  a_prod_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (snap_valid_i && prod_ready) |=> prod_v_q)
    else $error("snapshot taken but product stage empty");

  a_prod_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prod_v_q && !out_ready) |=> (prod_v_q && $stable(prod1_q)))
    else $error("blocked product stage lost its request");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prod_v_q && out_ready) |=> out_v_q)
    else $error("product stage drained without filling output");

endmodule

`default_nettype wire

### rtl/spectrum_top_two_peak_finder_unit.sv
// Spectrum top-two peak finder. Takes magnitude bins of an N-point spectrum
// (N = 2^log2_length, clamped to 4..MAX_LOG2_LEN) in order, one bin per
// cycle, and counts them itself: bin 0 sets the DC level, bins 1..N/2-1
// track the two largest magnitudes, the upper half is ignored. The last bin
// of a frame produces one request with DC level, two frequencies and two
// amplitudes; it reaches the output through the snapshot register, the
// index-times-rate multiplier register and the shift register. The input
// is stalled only while a finished frame waits behind a stalled output;
// otherwise bins flow at one per cycle. Configuration is
// on an APB port: log2_length at 0x0, sample_rate_hz at 0x4.
`timescale 1ns / 1ps
`default_nettype none

module spectrum_top_two_peak_finder_unit
  import stf_pkg::*;
#(
  parameter int unsigned MAG_WIDTH    = DEF_MAG_WIDTH,
  parameter int unsigned MAX_LOG2_LEN = DEF_MAX_LOG2_LEN
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [MAG_WIDTH-1:0]  bin_magnitude_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [DC_W-1:0]            dc_level_o,
  output logic [FREQ_W-1:0]          peak1_freq_hz_o,
  output logic [FREQ_W-1:0]          peak2_freq_hz_o,
  output logic [AMP_W-1:0]           peak1_level_o,
  output logic [AMP_W-1:0]           peak2_level_o
);

  localparam int unsigned LW = $clog2(MAX_LOG2_LEN + 1);
  localparam int unsigned IW = MAX_LOG2_LEN - 1;

  logic [LOG2_LEN_W-1:0] log2_len_q;
  logic [RATE_W-1:0]     rate_q;
  logic [LW-1:0]         eff_l;
  logic                  cfg_wr;
  reg_idx_e              reg_idx;

  logic                 snap_valid;
  logic                 snap_ready;
  logic [MAG_WIDTH-1:0] snap_dc;
  logic [MAG_WIDTH-1:0] snap_p1v;
  logic [MAG_WIDTH-1:0] snap_p2v;
  logic [IW-1:0]        snap_p1i;
  logic [IW-1:0]        snap_p2i;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_len_q <= LOG2_LEN_RST;
      rate_q     <= RATE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_LOG2_LEN: log2_len_q <= pwdata[LOG2_LEN_W-1:0];
        REG_RATE:     rate_q     <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LOG2_LEN: prdata = APB_DATA_W'(log2_len_q);
      REG_RATE:     prdata = APB_DATA_W'(rate_q);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    if (32'(log2_len_q) < 32'(MIN_LOG2_LEN)) begin
      eff_l = LW'(MIN_LOG2_LEN);
    end else if (32'(log2_len_q) > 32'(MAX_LOG2_LEN)) begin
      eff_l = LW'(MAX_LOG2_LEN);
    end else begin
      eff_l = LW'(log2_len_q);
    end
  end

  stf_tracker #(
    .MAG_WIDTH    (MAG_WIDTH),
    .MAX_LOG2_LEN (MAX_LOG2_LEN),
    .LW           (LW),
    .IW           (IW)
  ) u_tracker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .eff_l_i         (eff_l),
    .bin_valid_i     (in_valid_i),
    .bin_magnitude_i (bin_magnitude_i),
    .bin_stall_o     (in_stall_o),
    .snap_valid_o    (snap_valid),
    .snap_ready_i    (snap_ready),
    .snap_dc_o       (snap_dc),
    .snap_p1v_o      (snap_p1v),
    .snap_p2v_o      (snap_p2v),
    .snap_p1i_o      (snap_p1i),
    .snap_p2i_o      (snap_p2i)
  );

  stf_scale #(
    .MAG_WIDTH    (MAG_WIDTH),
    .MAX_LOG2_LEN (MAX_LOG2_LEN),
    .LW           (LW),
    .IW           (IW)
  ) u_scale (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .eff_l_i         (eff_l),
    .rate_i          (rate_q),
    .snap_valid_i    (snap_valid),
    .snap_ready_o    (snap_ready),
    .snap_dc_i       (snap_dc),
    .snap_p1v_i      (snap_p1v),
    .snap_p2v_i      (snap_p2v),
    .snap_p1i_i      (snap_p1i),
    .snap_p2i_i      (snap_p2i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .dc_level_o      (dc_level_o),
    .peak1_freq_hz_o (peak1_freq_hz_o),
    .peak2_freq_hz_o (peak2_freq_hz_o),
    .peak1_level_o   (peak1_level_o),
    .peak2_level_o   (peak2_level_o)
  );

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import stf_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_BINS = 250;
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  typedef struct packed {
    logic [DC_W-1:0]   dc;
    logic [FREQ_W-1:0] peak1_freq;
    logic [FREQ_W-1:0] peak2_freq;
    logic [AMP_W-1:0]  peak1_level;
    logic [AMP_W-1:0]  peak2_level;
  } peak_report_t;

  typedef struct packed {
    logic [LOG2_LEN_W-1:0] l2;
    logic [RATE_W-1:0]     rate;
    logic [31:0]           dc;
    logic [31:0]           fill;
    logic [31:0]           hi;
    logic [12:0]           p1_pos;
    logic [31:0]           p1_mag;
    logic [12:0]           p2_pos;
    logic [31:0]           p2_mag;
    logic [12:0]           cut_at;
    logic [LOG2_LEN_W-1:0] cut_l2;
    logic                  scatter;
    logic                  typed;
    peak_report_t          want;
  } frame_row_t;

  localparam frame_row_t PLAN [12] = '{
    '{4'd10, 27'd1000000, 32'd5120, 32'd0, 32'd0, 13'd100, 32'd4096, 13'd7, 32'd2048,
      13'd0, 4'd0, 1'b0, 1'b1, '{28'd5, 26'd97656, 26'd6835, 29'd8, 29'd4}},
    '{4'd4, 27'd16, 32'd0, 32'd0, 32'd0, 13'd0, 32'd0, 13'd0, 32'd0,
      13'd0, 4'd0, 1'b0, 1'b1, '0},
    '{4'd4, 27'd1000, 32'd0, 32'd300, 32'd0, 13'd0, 32'd0, 13'd0, 32'd0,
      13'd0, 4'd0, 1'b0, 1'b1, '{28'd0, 26'd62, 26'd125, 29'd37, 29'd37}},
    '{4'd4, RATE_MAX, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 13'd7, 32'hFFFF_FFFF,
      13'd6, 32'hFFFF_FFFE, 13'd0, 4'd0, 1'b0, 1'b0, '0},
    '{4'd4, 27'd48000, 32'd33, 32'd1, 32'd0, 13'd3, 32'd100, 13'd6, 32'd200,
      13'd0, 4'd0, 1'b0, 1'b0, '0},
    '{4'd4, 27'd1000000, 32'd0, 32'd10, 32'hFFFF_FFFF, 13'd7, 32'd20, 13'd0, 32'd0,
      13'd0, 4'd0, 1'b0, 1'b0, '0},
    '{4'd0, 27'd1600, 32'd1600, 32'd5, 32'd7, 13'd2, 32'd80, 13'd5, 32'd40,
      13'd0, 4'd0, 1'b0, 1'b0, '0},
    '{4'd15, 27'd100000000, 32'h8000_0000, 32'd0, 32'd0, 13'd120, 32'hFFFF_FFFF,
      13'd1, 32'd1, 13'd150, 4'd4, 1'b0, 1'b0, '0},
    '{4'd5, 27'd0, 32'd64, 32'd3, 32'd0, 13'd9, 32'd900, 13'd15, 32'd800,
      13'd0, 4'd0, 1'b0, 1'b0, '0},
    '{4'd6, 27'd12345, 32'd100, 32'd2, 32'd9, 13'd20, 32'd500, 13'd12, 32'd400,
      13'd40, 4'd4, 1'b0, 1'b0, '0},
    '{4'd6, 27'd12345, 32'd100, 32'd2, 32'd9, 13'd3, 32'd500, 13'd10, 32'd400,
      13'd5, 4'd4, 1'b0, 1'b0, '0},
    '{4'd4, 27'd999, 32'd0, 32'd4, 32'd6, 13'd5, 32'd70, 13'd12, 32'd60,
      13'd10, 4'd5, 1'b0, 1'b0, '0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [DEF_MAG_WIDTH-1:0] bin_magnitude_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [DC_W-1:0]       dc_level_o;
  logic [FREQ_W-1:0]     peak1_freq_hz_o;
  logic [FREQ_W-1:0]     peak2_freq_hz_o;
  logic [AMP_W-1:0]      peak1_level_o;
  logic [AMP_W-1:0]      peak2_level_o;

  spectrum_top_two_peak_finder_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .bin_magnitude_i (bin_magnitude_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .dc_level_o      (dc_level_o),
    .peak1_freq_hz_o (peak1_freq_hz_o),
    .peak2_freq_hz_o (peak2_freq_hz_o),
    .peak1_level_o   (peak1_level_o),
    .peak2_level_o   (peak2_level_o)
  );

  // shadow registers and peak tracker
  logic [LOG2_LEN_W-1:0] cfg_l2;
  logic [RATE_W-1:0]     cfg_rate;
  int unsigned           frame_pos;
  logic [31:0]           dc_mag;
  logic [31:0]           top_mag;
  logic [31:0]           next_mag;
  logic [11:0]           top_idx;
  logic [11:0]           next_idx;
  peak_report_t          report_q[$];
  peak_report_t          typed_report;
  bit                    typed_armed;

  // edge snapshots, taken at the falling edge
  bit                    in_take_s;
  bit                    out_take_s;
  bit                    pready_s;
  logic [31:0]           bin_s;
  logic [APB_DATA_W-1:0] prdata_s;
  peak_report_t          got_s;

  int                    mismatches;
  int unsigned           quiet;
  int unsigned           bins_sent;
  logic [31:0]           last_mag;
  bit                    tx_gappy;
  bit                    rx_random;
  int                    hold_reqs;
  int                    hold_seen;
  int                    stall_left;
  int                    free_left;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int unsigned span_log2(input logic [LOG2_LEN_W-1:0] l2);
    if (l2 < MIN_LOG2_LEN) return MIN_LOG2_LEN;
    if (l2 > DEF_MAX_LOG2_LEN) return DEF_MAX_LOG2_LEN;
    return int'(l2);
  endfunction

  task automatic flag_error(input string what, input logic [63:0] want,
                            input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %s: expected %0d got %0d", what, want, got);
    end
  endtask

  task automatic clear_tracker();
    frame_pos = 0;
    dc_mag = '0;
    top_mag = '0;
    next_mag = '0;
    top_idx = '0;
    next_idx = '0;
  endtask

  task automatic absorb_bin(input logic [31:0] mag);
    int unsigned  l;
    int unsigned  n;
    logic [63:0]  f1;
    logic [63:0]  f2;
    logic [32:0]  a1;
    logic [32:0]  a2;
    peak_report_t rep;
    l = span_log2(cfg_l2);
    n = 1 << l;
    if (frame_pos == 0) begin
      dc_mag = mag;
    end else if (frame_pos < (n >> 1)) begin
      if (mag > top_mag) begin
        next_mag = top_mag;
        next_idx = top_idx;
        top_mag = mag;
        top_idx = 12'(frame_pos);
      end else if (mag > next_mag) begin
        next_mag = mag;
        next_idx = 12'(frame_pos);
      end
    end
    if (frame_pos >= n - 1) begin
      f1 = (64'(top_idx) * 64'(cfg_rate)) >> l;
      f2 = (64'(next_idx) * 64'(cfg_rate)) >> l;
      a1 = {top_mag, 1'b0} >> l;
      a2 = {next_mag, 1'b0} >> l;
      rep.dc = DC_W'(dc_mag >> l);
      rep.peak1_freq = FREQ_W'(f1);
      rep.peak2_freq = FREQ_W'(f2);
      rep.peak1_level = AMP_W'(a1);
      rep.peak2_level = AMP_W'(a2);
      if (typed_armed) begin
        rep = typed_report;
        typed_armed = 1'b0;
      end
      report_q.push_back(rep);
      clear_tracker();
    end else begin
      frame_pos++;
    end
  endtask

  always @(negedge clk_i) begin
    in_take_s = (in_valid_i === 1'b1) && (in_stall_o === 1'b0);
    out_take_s = (out_valid_o === 1'b1) && (out_stall_i === 1'b0);
    pready_s = (pready === 1'b1);
    bin_s = bin_magnitude_i;
    prdata_s = prdata;
    got_s = '{dc_level_o, peak1_freq_hz_o, peak2_freq_hz_o, peak1_level_o, peak2_level_o};
  end

  always @(posedge clk_i) begin
    peak_report_t want;
    if (rst_ni) begin
      if (in_take_s) absorb_bin(bin_s);
      if (out_take_s) begin
        if (report_q.size() == 0) begin
          flag_error("unexpected request dc_level", 0, got_s.dc);
        end else begin
          want = report_q.pop_front();
          if (got_s.dc !== want.dc) flag_error("dc_level", want.dc, got_s.dc);
          if (got_s.peak1_freq !== want.peak1_freq)
            flag_error("peak1_freq_hz", want.peak1_freq, got_s.peak1_freq);
          if (got_s.peak2_freq !== want.peak2_freq)
            flag_error("peak2_freq_hz", want.peak2_freq, got_s.peak2_freq);
          if (got_s.peak1_level !== want.peak1_level)
            flag_error("peak1_level", want.peak1_level, got_s.peak1_level);
          if (got_s.peak2_level !== want.peak2_level)
            flag_error("peak2_level", want.peak2_level, got_s.peak2_level);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_take_s || out_take_s || psel) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // output stall: random runs, plus a long hold on request
  always @(posedge clk_i) begin
    int r;
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      stall_left = HOLD_CYCLES;
      free_left = 0;
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (!rx_random || free_left > 0) begin
      out_stall_i <= 1'b0;
      if (free_left > 0) free_left--;
    end else begin
      r = $urandom_range(0, 99);
      stall_left = (r < 8) ? $urandom_range(15, 60) : $urandom_range(1, 3);
      free_left = (r >= 90) ? $urandom_range(40, 150) : $urandom_range(0, 6);
      out_stall_i <= 1'b1;
      stall_left--;
    end
  end

  function automatic int pick_gap();
    int r;
    if (!tx_gappy) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function logic [31:0] pick_mag();
    int          r;
    logic [31:0] m;
    r = $urandom_range(0, 99);
    if (r < 6) m = '0;
    else if (r < 12) m = '1;
    else if (r < 24) m = last_mag;
    else if (r < 40) m = $urandom_range(0, 15);
    else m = $urandom;
    last_mag = m;
    return m;
  endfunction

  function automatic logic [LOG2_LEN_W-1:0] pick_l2();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 4'd4;
    if (r < 70) return LOG2_LEN_W'($urandom_range(0, 3));
    if (r < 88) return 4'd5;
    if (r < 96) return 4'd6;
    return 4'd7;
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return RATE_MAX;
    if (r < 30) return RATE_W'(100000000);
    if (r < 35) return RATE_W'(1);
    return RATE_W'($urandom_range(1, int'(RATE_MAX)));
  endfunction

  task automatic send_bin(input logic [31:0] mag);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    bin_magnitude_i <= mag;
    do @(posedge clk_i); while (!in_take_s);
    bins_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(int'(idx) * 4);
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready_s);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_LOG2_LEN) cfg_l2 = data[LOG2_LEN_W-1:0];
    else cfg_rate = data[RATE_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic apb_read(input reg_idx_e idx, output logic [APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= APB_ADDR_W'(int'(idx) * 4);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready_s);
    data = prdata_s;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_regs();
    logic [APB_DATA_W-1:0] v;
    apb_read(REG_LOG2_LEN, v);
    if (v !== APB_DATA_W'(cfg_l2)) flag_error("log2_length readback", cfg_l2, v);
    apb_read(REG_RATE, v);
    if (v !== APB_DATA_W'(cfg_rate)) flag_error("sample_rate_hz readback", cfg_rate, v);
  endtask

  task automatic retune(input logic [LOG2_LEN_W-1:0] l2, input logic [RATE_W-1:0] rate);
    settle();
    apb_write(REG_LOG2_LEN, APB_DATA_W'(l2));
    apb_write(REG_RATE, APB_DATA_W'(rate));
    check_regs();
  endtask

  function logic [31:0] bin_for(input frame_row_t fr, input int unsigned pos);
    int unsigned half;
    half = (1 << span_log2(cfg_l2)) >> 1;
    if (pos == 0) return fr.dc;
    if (pos == fr.p1_pos) return fr.p1_mag;
    if (pos == fr.p2_pos) return fr.p2_mag;
    if (fr.scatter) return pick_mag();
    return (pos < half) ? fr.fill : fr.hi;
  endfunction

  task automatic play_frame(input frame_row_t fr);
    int unsigned n;
    int unsigned pos;
    int unsigned stop;
    n = 1 << span_log2(cfg_l2);
    stop = (fr.cut_at != 0) ? fr.cut_at : n;
    for (pos = 0; pos < stop; pos++) send_bin(bin_for(fr, pos));
    if (fr.cut_at != 0) begin
      settle();
      apb_write(REG_LOG2_LEN, APB_DATA_W'(fr.cut_l2));
      check_regs();
      n = 1 << span_log2(cfg_l2);
      do begin
        send_bin(bin_for(fr, pos));
        pos++;
      end while (pos < n);
    end
  endtask

  initial begin
    frame_row_t fr;
    int unsigned n;
    rst_ni = 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid_i <= 1'b0;
    bin_magnitude_i <= '0;
    out_stall_i <= 1'b0;
    cfg_l2 = LOG2_LEN_RST;
    cfg_rate = RATE_RST;
    clear_tracker();
    typed_armed = 1'b0;
    mismatches = 0;
    quiet = 0;
    bins_sent = 0;
    last_mag = '0;
    tx_gappy = 1'b0;
    rx_random = 1'b0;
    hold_reqs = 0;
    hold_seen = 0;
    stall_left = 0;
    free_left = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_regs();

    for (int i = 0; i < $size(PLAN); i++) begin
      settle();
      if (PLAN[i].l2 != cfg_l2 || PLAN[i].rate != cfg_rate) retune(PLAN[i].l2, PLAN[i].rate);
      if (PLAN[i].typed) begin
        typed_report = PLAN[i].want;
        typed_armed = 1'b1;
      end
      tx_gappy = i[0];
      rx_random = i[1];
      play_frame(PLAN[i]);
    end

    // fill the block behind a long output hold
    retune(4'd4, pick_rate());
    tx_gappy = 1'b0;
    rx_random = 1'b1;
    hold_reqs <= hold_reqs + 1;
    fr = '0;
    fr.scatter = 1'b1;
    repeat (10) play_frame(fr);

    bins_sent = 0;
    while (bins_sent < RANDOM_BINS) begin
      if ($urandom_range(0, 3) == 0) begin
        retune(pick_l2(), pick_rate());
        tx_gappy = ($urandom_range(0, 9) >= 3);
        rx_random = ($urandom_range(0, 9) >= 3);
      end
      n = 1 << span_log2(cfg_l2);
      fr = '0;
      fr.scatter = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        fr.cut_at = 13'($urandom_range(1, n - 2));
        fr.cut_l2 = pick_l2();
      end
      play_frame(fr);
    end

    rx_random = 1'b0;
    settle();
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

### sim.f
rtl/stf_pkg.sv
rtl/stf_tracker.sv
rtl/stf_scale.sv
rtl/spectrum_top_two_peak_finder_unit.sv
bench/tb_top.sv
